// File: rtl/core/swv_pkg.sv
// Shared types, constants and microcode field codes for the sliding window variance block.
// Depends on nothing; every other file of the block but swv_ram depends on it.
package swv_pkg;

	// Default sizes of the block.
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// Window length register.
	localparam int CFG_W      = 7;
	localparam int WLEN_RESET = 50;
	localparam int WLEN_MIN   = 2;

	// Result format: LSB squared with four fraction bits.
	localparam int VAR_W     = 36;
	localparam int FRAC_BITS = 4;

	// Step counter of the sequencer.
	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	// Datapath operations, one per control word.
	typedef logic [3:0] op_t;
	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_ACCEPT   = 4'd1;
	localparam op_t OP_SQ_X     = 4'd2;
	localparam op_t OP_ADD_X    = 4'd3;
	localparam op_t OP_SUB_OLD  = 4'd4;
	localparam op_t OP_SQ_S     = 4'd5;
	localparam op_t OP_NSQ      = 4'd6;
	localparam op_t OP_NUM      = 4'd7;
	localparam op_t OP_DIV_INIT = 4'd8;
	localparam op_t OP_DIV_STEP = 4'd9;
	localparam op_t OP_SAT      = 4'd10;
	localparam op_t OP_EMIT     = 4'd11;

	// Conditions for waiting and jumping.
	typedef logic [2:0] cond_t;
	localparam cond_t C_NEVER    = 3'd0;
	localparam cond_t C_ALWAYS   = 3'd1;
	localparam cond_t C_NO_INPUT = 3'd2;
	localparam cond_t C_OUT_BUSY = 3'd3;
	localparam cond_t C_NOT_FULL = 3'd4;
	localparam cond_t C_DIV_MORE = 3'd5;

	// One word of the microprogram.
	typedef struct packed {
		op_t   op;
		cond_t wait_cond;
		cond_t jmp_cond;
		pc_t   jmp_tgt;
	} ctrl_word_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		op_t  op;
		logic run;
	} dp_ctrl_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic no_input;
		logic out_busy;
		logic not_full;
		logic div_more;
	} dp_status_t;

endpackage

// File: rtl/core/swv_sample_if.sv
// Input channel of the sliding window variance block: valid, ready and one signed sample.
// Depends on swv_pkg for the default sample width.
interface swv_sample_if #(
	parameter int SAMPLE_BITS = swv_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// File: rtl/core/swv_result_if.sv
// Output channel of the sliding window variance block: valid, ready, full flag and variance.
// Depends on swv_pkg for the variance width.
interface swv_result_if;
	import swv_pkg::*;

	logic             valid;
	logic             ready;
	logic             window_full;
	logic [VAR_W-1:0] variance;

	modport source (output valid, output window_full, output variance, input ready);
	modport sink (input valid, input window_full, input variance, output ready);
endinterface

// File: rtl/core/swv_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; used for the sample ring.
module swv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/swv_seq.sv
// Microcode sequencer: step counter, read-only program and wait and jump conditions.
// Depends on swv_pkg for the control word, status and code definitions.
module swv_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  swv_pkg::dp_status_t status,
	output swv_pkg::dp_ctrl_t   ctrl
);
	import swv_pkg::*;

	// Step addresses of the program.
	localparam pc_t S_IDLE     = 4'd0;
	localparam pc_t S_SQ_X     = 4'd1;
	localparam pc_t S_ADD_X    = 4'd2;
	localparam pc_t S_SUB_OLD  = 4'd3;
	localparam pc_t S_SQ_S     = 4'd4;
	localparam pc_t S_NSQ      = 4'd5;
	localparam pc_t S_NUM      = 4'd6;
	localparam pc_t S_DIV_INIT = 4'd7;
	localparam pc_t S_DIV      = 4'd8;
	localparam pc_t S_SAT      = 4'd9;
	localparam pc_t S_EMIT     = 4'd10;

	// The microprogram. A step waits while its wait condition holds, then runs its
	// operation and jumps if its jump condition holds, otherwise falls through.
	function automatic ctrl_word_t rom(pc_t addr);
		ctrl_word_t w;
		w.op        = OP_NOP;
		w.wait_cond = C_NEVER;
		w.jmp_cond  = C_NEVER;
		w.jmp_tgt   = S_IDLE;
		unique case (addr)
			S_IDLE: begin
				w.op        = OP_ACCEPT;
				w.wait_cond = C_NO_INPUT;
			end
			S_SQ_X:     w.op = OP_SQ_X;
			S_ADD_X:    w.op = OP_ADD_X;
			S_SUB_OLD: begin
				w.op       = OP_SUB_OLD;
				w.jmp_cond = C_NOT_FULL;
				w.jmp_tgt  = S_EMIT;
			end
			S_SQ_S:     w.op = OP_SQ_S;
			S_NSQ:      w.op = OP_NSQ;
			S_NUM:      w.op = OP_NUM;
			S_DIV_INIT: w.op = OP_DIV_INIT;
			S_DIV: begin
				w.op       = OP_DIV_STEP;
				w.jmp_cond = C_DIV_MORE;
				w.jmp_tgt  = S_DIV;
			end
			S_SAT:      w.op = OP_SAT;
			S_EMIT: begin
				w.op        = OP_EMIT;
				w.wait_cond = C_OUT_BUSY;
				w.jmp_cond  = C_ALWAYS;
				w.jmp_tgt   = S_IDLE;
			end
			default: begin
				w.jmp_cond = C_ALWAYS;
			end
		endcase
		return w;
	endfunction

	// Evaluation of a condition code against the datapath status.
	function automatic logic cond_true(cond_t c, dp_status_t s);
		logic r;
		unique case (c)
			C_NEVER:    r = 1'b0;
			C_ALWAYS:   r = 1'b1;
			C_NO_INPUT: r = s.no_input;
			C_OUT_BUSY: r = s.out_busy;
			C_NOT_FULL: r = s.not_full;
			C_DIV_MORE: r = s.div_more;
			default:    r = 1'b0;
		endcase
		return r;
	endfunction

	pc_t        pc_q;
	pc_t        pc_next;
	ctrl_word_t word;
	logic       waiting;

	// Decode of the current step.
	always_comb begin
		word    = rom(pc_q);
		waiting = cond_true(word.wait_cond, status);
		priority if (waiting) begin
			pc_next = pc_q;
		end else if (cond_true(word.jmp_cond, status)) begin
			pc_next = word.jmp_tgt;
		end else begin
			pc_next = pc_q + pc_t'(1);
		end
		ctrl.op  = word.op;
		ctrl.run = !waiting;
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end
endmodule

// File: rtl/core/swv_dp.sv
// Datapath of the sliding window variance block: window state, sample ring, shared
// multiplier, restoring divider and output register. Depends on swv_pkg and swv_ram.
module swv_dp #(
	parameter int WINDOW_MAX  = swv_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swv_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [swv_pkg::CFG_W-1:0]     cfg_wr_data,
	input  swv_pkg::dp_ctrl_t             ctrl,
	output swv_pkg::dp_status_t           status,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_window_full,
	output logic [swv_pkg::VAR_W-1:0]     out_variance
);
	import swv_pkg::*;

	localparam int LOG_W   = $clog2(WINDOW_MAX);
	localparam int P_W     = LOG_W;
	localparam int N_W     = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W   = (CFG_W > N_W) ? CFG_W : N_W;
	// One spare bit in the sum, as the new sample is added before the oldest is removed.
	localparam int SUM_W   = SAMPLE_BITS + LOG_W + 1;
	localparam int SQ_W    = 2 * SAMPLE_BITS + LOG_W;
	localparam int PROD_W  = SQ_W + SUM_W;
	localparam int D_W     = 2 * N_W;
	localparam int NUM_W   = SQ_W + N_W + FRAC_BITS;
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int NUM_EXT = (NUM_W > VAR_W) ? NUM_W : VAR_W + 1;
	localparam int N_RESET = (WLEN_RESET > WINDOW_MAX) ? WINDOW_MAX : WLEN_RESET;

	// Window state.
	logic [N_W-1:0]          n_q;
	logic [P_W-1:0]          wp_q;
	logic [N_W-1:0]          fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sq_q;
	logic [VAR_W-1:0]        held_q;
	logic                    evict_q;
	logic                    full_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;

	// Working registers.
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic [PROD_W-1:0]             prod_q;
	logic [NUM_W-1:0]              num_q;
	logic [D_W-1:0]                rem_q;
	logic [D_W-1:0]                div_q;
	logic                          out_full_q;
	logic [VAR_W-1:0]              out_var_q;

	logic [SAMPLE_BITS-1:0]     ring_rdata;
	logic [CMP_W-1:0]           wl_ext;
	logic [N_W-1:0]             n_wr;
	logic [P_W-1:0]             p;
	logic [N_W-1:0]             p_inc;
	logic [P_W-1:0]             p_next;
	logic [SAMPLE_BITS-1:0]     abs_x;
	logic [SAMPLE_BITS-1:0]     abs_old;
	logic [SUM_W-1:0]           abs_sum;
	logic [SQ_W-1:0]            mul_a;
	logic [SUM_W-1:0]           mul_b;
	logic                       mul_en;
	logic [PROD_W-1:0]          product;
	logic [NUM_W-FRAC_BITS-1:0] diff;
	logic [D_W:0]               shifted;
	logic [D_W:0]               trial;
	logic                       q_bit;
	logic [D_W-1:0]             rem_next;
	logic [NUM_EXT-1:0]         q_ext;
	logic [VAR_W-1:0]           sat;

	// Window length as written, limited to the supported range.
	always_comb begin
		wl_ext = CMP_W'(cfg_wr_data);
		priority if (wl_ext < CMP_W'(WLEN_MIN)) begin
			n_wr = N_W'(WLEN_MIN);
		end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
			n_wr = N_W'(WINDOW_MAX);
		end else begin
			n_wr = N_W'(wl_ext);
		end
	end

	// Ring slot of this sample and the slot after it.
	always_comb begin
		p      = (N_W'(wp_q) < n_q) ? wp_q : '0;
		p_inc  = N_W'(p) + N_W'(1);
		p_next = (p_inc >= n_q) ? '0 : P_W'(p_inc);
	end

	// Magnitudes feeding the multiplier.
	always_comb begin
		abs_x   = x_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_q) : SAMPLE_BITS'(x_q);
		abs_old = old_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-old_q) : SAMPLE_BITS'(old_q);
		abs_sum = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	end

	// Operand selection of the shared multiplier.
	always_comb begin
		unique case (ctrl.op)
			OP_SQ_X: begin
				mul_a  = SQ_W'(abs_x);
				mul_b  = SUM_W'(abs_x);
				mul_en = 1'b1;
			end
			OP_ADD_X: begin
				mul_a  = SQ_W'(abs_old);
				mul_b  = SUM_W'(abs_old);
				mul_en = 1'b1;
			end
			OP_SQ_S: begin
				mul_a  = SQ_W'(abs_sum);
				mul_b  = abs_sum;
				mul_en = 1'b1;
			end
			OP_NSQ: begin
				mul_a  = sq_q;
				mul_b  = SUM_W'(n_q);
				mul_en = 1'b1;
			end
			OP_NUM: begin
				mul_a  = SQ_W'(n_q);
				mul_b  = SUM_W'(n_q - N_W'(1));
				mul_en = 1'b1;
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				mul_en = 1'b0;
			end
		endcase
		product = {{SUM_W{1'b0}}, mul_a} * {{SQ_W{1'b0}}, mul_b};
	end

	// Numerator, one restoring division step and saturation of the quotient.
	always_comb begin
		diff     = prod_q[NUM_W-FRAC_BITS-1:0] - num_q[NUM_W-FRAC_BITS-1:0];
		shifted  = {rem_q, num_q[NUM_W-1]};
		trial    = shifted - {1'b0, div_q};
		q_bit    = !trial[D_W];
		rem_next = q_bit ? trial[D_W-1:0] : shifted[D_W-1:0];
		q_ext    = NUM_EXT'(num_q);
		sat      = (|q_ext[NUM_EXT-1:VAR_W]) ? {VAR_W{1'b1}} : q_ext[VAR_W-1:0];
	end

	// Status for the sequencer and the channel handshakes.
	always_comb begin
		status.no_input = !in_valid;
		status.out_busy = out_valid_q && !out_ready;
		status.not_full = fill_q < n_q;
		status.div_more = cnt_q != '0;
	end

	assign in_ready        = (ctrl.op == OP_ACCEPT);
	assign out_valid       = out_valid_q;
	assign out_window_full = out_full_q;
	assign out_variance    = out_var_q;

	// Sample ring.
	swv_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (ctrl.run && (ctrl.op == OP_ADD_X)),
		.waddr (p),
		.wdata (x_q),
		.raddr (p),
		.rdata (ring_rdata)
	);

	// Window state, divider count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= N_W'(N_RESET);
			wp_q        <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			held_q      <= '0;
			evict_q     <= 1'b0;
			full_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register refills on the emit step and empties on its transaction.
			if (ctrl.run && (ctrl.op == OP_EMIT)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// A new window length restarts the fill; the held variance stays.
			if (cfg_wr_en) begin
				n_q    <= n_wr;
				wp_q   <= '0;
				fill_q <= '0;
				sum_q  <= '0;
				sq_q   <= '0;
			end else if (ctrl.run) begin
				unique case (ctrl.op)
					OP_ADD_X: begin
						sum_q   <= sum_q + SUM_W'(x_q);
						sq_q    <= sq_q + prod_q[SQ_W-1:0];
						evict_q <= !status.not_full;
						if (status.not_full) begin
							fill_q <= fill_q + N_W'(1);
						end
					end
					OP_SUB_OLD: begin
						if (evict_q) begin
							sum_q <= sum_q - SUM_W'(old_q);
							sq_q  <= sq_q - prod_q[SQ_W-1:0];
						end
						wp_q   <= p_next;
						full_q <= !status.not_full;
					end
					OP_DIV_INIT: cnt_q <= CNT_W'(NUM_W - 1);
					OP_DIV_STEP: begin
						// The count stops at zero on the last quotient bit.
						if (status.div_more) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
					OP_SAT:      held_q <= sat;
					default: begin
					end
				endcase
			end
		end
	end

	// Working registers and output payload.
	always_ff @(posedge clk) begin
		if (ctrl.run && mul_en) begin
			prod_q <= product;
		end
		if (ctrl.run) begin
			unique case (ctrl.op)
				OP_ACCEPT: x_q   <= in_sample;
				OP_SQ_X:   old_q <= ring_rdata;
				OP_NSQ:    num_q <= prod_q[NUM_W-1:0];
				OP_NUM:    num_q <= {diff, FRAC_BITS'(0)};
				OP_DIV_INIT: begin
					div_q <= prod_q[D_W-1:0];
					rem_q <= '0;
				end
				OP_DIV_STEP: begin
					num_q <= {num_q[NUM_W-2:0], q_bit};
					rem_q <= rem_next;
				end
				OP_EMIT: begin
					out_full_q <= full_q;
					out_var_q  <= held_q;
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// File: rtl/core/sliding_window_variance_top.sv
// Sliding window variance: one result transaction per sample transaction.
// While the window fills, a sample runs accept, square, add, subtract and emit steps. With a full
// window the sum is squared and the numerator formed, and the restoring divider takes one step
// per quotient bit (49 at the default sizes) before saturation and emit. A new sample is taken
// only after that emit. A result left waiting holds the next one at its last step.
// Reset empties the window, sets the length to 50 (at most WINDOW_MAX) and clears the held variance; ring kept.
module sliding_window_variance_top #(
	parameter int WINDOW_MAX  = swv_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swv_pkg::SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [swv_pkg::CFG_W-1:0] cfg_wr_data,
	swv_sample_if.sink                samples,
	swv_result_if.source              results
);
	import swv_pkg::*;

	dp_ctrl_t   ctrl;
	dp_status_t status;

	// Microcode sequencer.
	swv_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Datapath.
	swv_dp #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.ctrl            (ctrl),
		.status          (status),
		.in_valid        (samples.valid),
		.in_ready        (samples.ready),
		.in_sample       (samples.sample),
		.out_valid       (results.valid),
		.out_ready       (results.ready),
		.out_window_full (results.window_full),
		.out_variance    (results.variance)
	);

	// A sample transaction starts a program run, so the next cycle cannot take another.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("sample taken while the previous one was still in progress");

	// Writing the window length always leaves a window that is not yet full.
	a_restart_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> status.not_full)
		else $error("window reported full straight after a length write");

	// The divider count is only live while the division step runs.
	a_div_count_local: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_more |-> ctrl.op == OP_DIV_STEP)
		else $error("divider count nonzero outside the division step");
endmodule
